@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/gdsu_pkg.sv @@
package gdsu_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int ORD_W   = 9;

   // floor(y * 5243 / 2^19) equals floor(y / 100) for every 14-bit year.
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

   typedef struct packed {
      logic [DAY_W-1:0]   day_in;
      logic [MONTH_W-1:0] month_in;
      logic [YEAR_W-1:0]  year_in;
   } req_type;

   typedef struct packed {
      logic               date_valid;
      logic [DAY_W-1:0]   succ_day;
      logic [MONTH_W-1:0] succ_month;
      logic [YEAR_W-1:0]  succ_year;
      logic [DAY_W-1:0]   pred_day;
      logic [MONTH_W-1:0] pred_month;
      logic [YEAR_W-1:0]  pred_year;
      logic [ORD_W-1:0]   ordinal_day;
   } rsp_type;

   // Stage one to stage two: the date and its year divided by 100.
   typedef struct packed {
      logic              vld;
      req_type           req;
      logic [QUOT_W-1:0] quot;
   } s1_type;

   // Stage two to stage three: the date and its calendar checks.
   typedef struct packed {
      logic             vld;
      req_type          req;
      logic             ok;
      logic             leap;
      logic [DAY_W-1:0] mlen;
   } s2_type;

   // Length of a month; zero for codes that name no month.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic lp);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:    len = lp ? 5'd29 : 5'd28;
         default: len = '0;
      endcase
      return len;
   endfunction

   // Days in the months before month m of a common year.
   function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [ORD_W-1:0] n;
      unique case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage

@@ hdl/gdsu_div_stage.sv @@
module gdsu_div_stage
   import gdsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_vld,
   input  req_type in_req,
   output s1_type  out_s1
);

   logic [PROD_W-1:0] prod_in;
   logic              vld_ff;
   req_type           req_ff;
   logic [QUOT_W-1:0] quot_ff;

   // Reciprocal multiply stands in for the division by 100.
   assign prod_in = PROD_W'(in_req.year_in) * PROD_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= in_req;
      quot_ff <= prod_in[PROD_W-1:RECIP_SHIFT];
   end

   assign out_s1 = '{vld: vld_ff, req: req_ff, quot: quot_ff};

endmodule

@@ hdl/gdsu_check_stage.sv @@
module gdsu_check_stage
   import gdsu_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  s1_type in_s1,
   output s2_type out_s2
);

   logic [YEAR_W-1:0] hundreds;
   logic [YEAR_W-1:0] rem100;
   logic              div4;
   logic              div100;
   logic              div400;
   logic              leap_in;
   logic [DAY_W-1:0]  mlen_in;
   logic              month_ok;
   logic              ok_in;
   logic              vld_ff;
   req_type           req_ff;
   logic              ok_ff;
   logic              leap_ff;
   logic [DAY_W-1:0]  mlen_ff;

   assign hundreds = (YEAR_W'(in_s1.quot) << 6) + (YEAR_W'(in_s1.quot) << 5)
                   + (YEAR_W'(in_s1.quot) << 2);
   assign rem100   = in_s1.req.year_in - hundreds;
   assign div4     = (in_s1.req.year_in[1:0] == 2'b00);
   assign div100   = (rem100 == '0);
   // A multiple of 100 is a multiple of 400 when its hundreds count is a multiple of 4.
   assign div400   = div100 && (in_s1.quot[1:0] == 2'b00);
   assign leap_in  = (div4 && !div100) || div400;
   assign mlen_in  = month_length(in_s1.req.month_in, leap_in);
   assign month_ok = (in_s1.req.month_in >= MONTH_JAN) && (in_s1.req.month_in <= MONTH_DEC);
   assign ok_in    = month_ok && (in_s1.req.day_in >= DAY_FIRST)
                   && (in_s1.req.day_in <= mlen_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_s1.vld;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= in_s1.req;
      ok_ff   <= ok_in;
      leap_ff <= leap_in;
      mlen_ff <= mlen_in;
   end

   assign out_s2 = '{vld: vld_ff, req: req_ff, ok: ok_ff, leap: leap_ff, mlen: mlen_ff};

endmodule

@@ hdl/gdsu_step_stage.sv @@
module gdsu_step_stage
   import gdsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  s2_type  in_s2,
   output logic    out_strobe,
   output rsp_type out_rsp
);

   logic [DAY_W-1:0]   d;
   logic [MONTH_W-1:0] m;
   logic [YEAR_W-1:0]  y;
   logic               last_day;
   logic               first_day;
   rsp_type            rsp_in;
   logic               strobe_ff;
   rsp_type            rsp_ff;

   assign d         = in_s2.req.day_in;
   assign m         = in_s2.req.month_in;
   assign y         = in_s2.req.year_in;
   assign last_day  = (d == in_s2.mlen);
   assign first_day = (d == DAY_FIRST);

   always_comb begin
      rsp_in = '0;
      if (in_s2.ok) begin
         rsp_in.date_valid = 1'b1;

         if (!last_day) begin
            rsp_in.succ_day   = d + DAY_W'(1);
            rsp_in.succ_month = m;
            rsp_in.succ_year  = y;
         end else if (m == MONTH_DEC) begin
            rsp_in.succ_day   = DAY_FIRST;
            rsp_in.succ_month = MONTH_JAN;
            rsp_in.succ_year  = y + YEAR_W'(1);
         end else begin
            rsp_in.succ_day   = DAY_FIRST;
            rsp_in.succ_month = m + MONTH_W'(1);
            rsp_in.succ_year  = y;
         end

         if (!first_day) begin
            rsp_in.pred_day   = d - DAY_W'(1);
            rsp_in.pred_month = m;
            rsp_in.pred_year  = y;
         end else if (m == MONTH_JAN) begin
            rsp_in.pred_day   = DAY_LAST_DEC;
            rsp_in.pred_month = MONTH_DEC;
            rsp_in.pred_year  = y - YEAR_W'(1);
         end else begin
            rsp_in.pred_day   = month_length(m - MONTH_W'(1), in_s2.leap);
            rsp_in.pred_month = m - MONTH_W'(1);
            rsp_in.pred_year  = y;
         end

         rsp_in.ordinal_day = days_before(m) + ORD_W'(d)
                            + ORD_W'(in_s2.leap && (m > MONTH_FEB));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_s2.vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

@@ hdl/gregorian_date_step_unit_top.sv @@
// Pipeline: a transaction accepted at a clock edge passes three register stages (divide,
// check, step) before its result shows on rsp_data with rsp_strobe high.
// Throughput: one transaction per cycle; busy is always low, so start may stay high.
// Reset: synchronous, active high; it clears the stage valid bits, so no strobe
// follows reset until new transactions arrive. The receiver cannot stall the unit.
`include "assert_macros.svh"

module gregorian_date_step_unit_top
   import gdsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // The pipeline has no back pressure and no shared unit, so the unit takes
   // a new transaction in every cycle and never reports itself busy.
   s1_type s1;
   s2_type s2;

   assign busy = 1'b0;

   // Stage one multiplies the year by a reciprocal to get the year divided by 100.
   gdsu_div_stage u_div (
      .clock  (clock),
      .reset  (reset),
      .in_vld (start),
      .in_req (req_data),
      .out_s1 (s1)
   );

   // Stage two settles the leap year, the month length and whether the date exists.
   gdsu_check_stage u_check (
      .clock  (clock),
      .reset  (reset),
      .in_s1  (s1),
      .out_s2 (s2)
   );

   // Stage three forms the following and preceding dates and the day of the year,
   // and its output register drives the result port directly.
   gdsu_step_stage u_step (
      .clock      (clock),
      .reset      (reset),
      .in_s2      (s2),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_data)
   );

   // A valid bit in the middle of the pipeline moves on to the output in the next cycle.
   `ASSERT_NEXT(a_s2_to_strobe, clock, reset, s2.vld, rsp_strobe)
   // An invalid date carries no other result bits.
   `ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_strobe && !rsp_data.date_valid, rsp_data == '0)
   // A valid date always has a nonzero day number and following day.
   `ASSERT_IMPL(a_valid_nonzero, clock, reset, rsp_strobe && rsp_data.date_valid, rsp_data.ordinal_day != '0 && rsp_data.succ_day != '0)

endmodule

@@ tb/sv/gregorian_date_step_unit_top_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the Gregorian date step unit. Dates go in on the
// command port, and every accepted transaction leaves its predicted answer in
// a queue. Each strobed result is compared, field by field, with the oldest
// entry in that queue. The unit keeps no state, so the predictor is a pure
// function of the date.
module gregorian_date_step_unit_top_tb
   import gdsu_pkg::*;
();

   // The unit accepts a transaction or strobes a result on most cycles. Sender
   // gaps are far shorter than IDLE_LIMIT and the pipeline is three deep, so a
   // quiet run that reaches IDLE_LIMIT can only mean a hang.
   localparam int IDLE_LIMIT   = 1000;
   localparam int MAX_REPORTED = 40;
   localparam int YEAR_SPAN    = 1 << YEAR_W;

   // One transaction in flight: the date sent and the answer it must produce.
   typedef struct {
      req_type date;
      rsp_type answer;
   } date_step_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   date_step_type pending_steps[$];
   date_step_type oldest_step;
   int            mismatch_count = 0;
   int            idle_cycles    = 0;
   bit            no_gaps        = 1'b0;

   gregorian_date_step_unit_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Calendar predictor
   // ------------------------------------------------------------------

   // Length of a month in a given year, or zero when the month code names
   // no month. Leap years are divisible by 4 but not by 100, unless they
   // are divisible by 400; year 0 therefore counts as a leap year.
   function automatic int month_days(int month, int year);
      bit leap_year;
      leap_year = (year % 4 == 0 && year % 100 != 0) || (year % 400 == 0);
      case (month)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Works out the full answer for one date. An invalid date gives an
   // all-zero answer, the valid flag included.
   function automatic rsp_type predict_date_step(req_type date);
      rsp_type step;
      int      day;
      int      month;
      int      year;
      int      month_len;
      int      prior_month;
      int      prior_year;
      int      ordinal;
      step      = '0;
      day       = date.day_in;
      month     = date.month_in;
      year      = date.year_in;
      month_len = month_days(month, year);
      if (month_len == 0 || day < 1 || day > month_len) begin
         return step;
      end
      step.date_valid = 1'b1;

      // The following date rolls into the next month at the month's last
      // day and into the next year after December; the year wraps at 2^14.
      if (day < month_len) begin
         step.succ_day   = DAY_W'(day + 1);
         step.succ_month = MONTH_W'(month);
         step.succ_year  = YEAR_W'(year);
      end else if (month < int'(MONTH_DEC)) begin
         step.succ_day   = DAY_FIRST;
         step.succ_month = MONTH_W'(month + 1);
         step.succ_year  = YEAR_W'(year);
      end else begin
         step.succ_day   = DAY_FIRST;
         step.succ_month = MONTH_JAN;
         step.succ_year  = YEAR_W'((year + 1) % YEAR_SPAN);
      end

      // The preceding date borrows from the prior month on the first day,
      // and from December of the prior year on the first of January.
      if (day > 1) begin
         step.pred_day   = DAY_W'(day - 1);
         step.pred_month = MONTH_W'(month);
         step.pred_year  = YEAR_W'(year);
      end else begin
         prior_month     = (month == int'(MONTH_JAN)) ? int'(MONTH_DEC) : month - 1;
         prior_year      = (month == int'(MONTH_JAN)) ? (year + YEAR_SPAN - 1) % YEAR_SPAN
                                                      : year;
         step.pred_day   = DAY_W'(month_days(prior_month, prior_year));
         step.pred_month = MONTH_W'(prior_month);
         step.pred_year  = YEAR_W'(prior_year);
      end

      // The day of the year is the day plus every full month before it.
      ordinal = day;
      for (int k = 1; k < month; k++) begin
         ordinal += month_days(k, year);
      end
      step.ordinal_day = ORD_W'(ordinal);
      return step;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Most dates are well formed and lean on month ends, century years and
   // the ends of the 14-bit year range; the rest carry a bad month or day.
   function automatic req_type random_date();
      req_type date;
      int      roll;
      int      month;
      int      month_len;
      roll = $urandom_range(99, 0);
      if (roll < 40) begin
         date.year_in = YEAR_W'($urandom_range(9999, 1));
      end else if (roll < 55) begin
         date.year_in = YEAR_W'($urandom_range(YEAR_SPAN - 1, 0));
      end else if (roll < 70) begin
         date.year_in = YEAR_W'(100 * $urandom_range(163, 0));
      end else if (roll < 80) begin
         date.year_in = YEAR_W'(400 * $urandom_range(40, 0));
      end else if (roll < 90) begin
         date.year_in = YEAR_W'(4 * $urandom_range(YEAR_SPAN / 4 - 1, 0));
      end else begin
         case ($urandom_range(5, 0))
            0:       date.year_in = YEAR_W'(0);
            1:       date.year_in = YEAR_W'(1);
            2:       date.year_in = YEAR_W'(9999);
            3:       date.year_in = YEAR_W'(10000);
            4:       date.year_in = YEAR_W'(YEAR_SPAN - 2);
            default: date.year_in = YEAR_W'(YEAR_SPAN - 1);
         endcase
      end

      // A month code outside 1..12 is either zero or one of 13..15.
      if ($urandom_range(99, 0) < 88) begin
         month = $urandom_range(12, 1);
      end else begin
         month = $urandom_range(3, 0);
         if (month != 0) begin
            month += 12;
         end
      end
      date.month_in = MONTH_W'(month);

      month_len = month_days(month, int'(date.year_in));
      roll = $urandom_range(99, 0);
      if (month_len == 0 || roll >= 88) begin
         date.day_in = DAY_W'($urandom_range(31, 0));
      end else if (roll < 45) begin
         date.day_in = DAY_W'($urandom_range(month_len, 1));
      end else if (roll < 60) begin
         date.day_in = DAY_FIRST;
      end else if (roll < 80) begin
         date.day_in = DAY_W'(month_len);
      end else begin
         date.day_in = DAY_W'(month_len + 1);
      end
      return date;
   endfunction

   // Sender gaps: mostly none or short ones, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(30, 8);
   endfunction

   // Presents one date at a falling edge and holds it until a rising edge
   // sees busy low; that edge accepts the transaction. While start is low
   // the data lines carry noise, which the unit must ignore.
   task automatic send_date(input req_type date);
      date_step_type step;
      int            gap;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= date;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      step.date   = date;
      step.answer = predict_date_step(date);
      pending_steps.push_back(step);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= random_date();
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_dmy(input int day, input int month, input int year);
      req_type date;
      date.day_in   = DAY_W'(day);
      date.month_in = MONTH_W'(month);
      date.year_in  = YEAR_W'(year);
      send_date(date);
   endtask

   // Stops sending and waits until every outstanding transaction has been
   // answered.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_steps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked dates: field extremes, leap rules, month and year ends, the
   // year wrap in both directions, and each kind of invalid date.
   task automatic test_calendar_corners();
      send_dmy(1, 1, 1);
      send_dmy(31, 12, 9999);
      send_dmy(0, 0, 0);                 // every input bit low
      send_dmy(31, 15, YEAR_SPAN - 1);   // every input bit high
      send_dmy(29, 2, 2000);             // century divisible by 400 is leap
      send_dmy(29, 2, 1900);             // plain century is not leap
      send_dmy(28, 2, 1900);
      send_dmy(1, 3, 1900);
      send_dmy(29, 2, 2024);
      send_dmy(1, 3, 2024);
      send_dmy(31, 12, 2024);            // ordinal day 366
      send_dmy(1, 3, 2023);
      send_dmy(30, 2, 2024);
      send_dmy(31, 4, 2023);             // day past a 30-day month
      send_dmy(30, 4, 2023);
      send_dmy(0, 5, 2023);              // day zero
      send_dmy(15, 13, 2023);            // month past December
      send_dmy(10, 0, 2023);             // month zero
      send_dmy(31, 12, YEAR_SPAN - 1);   // next year wraps to zero
      send_dmy(1, 1, 0);                 // previous year wraps to the top
      send_dmy(29, 2, 0);                // year zero is leap
      send_dmy(1, 1, 10000);
      send_dmy(31, 1, 2023);
   endtask

   // Dates on every cycle, so start stays high across many transactions.
   task automatic test_back_to_back(input int count);
      no_gaps = 1'b1;
      repeat (count) send_date(random_date());
      no_gaps = 1'b0;
   endtask

   // Random dates with random sender gaps, broken up by short gap-free bursts.
   task automatic test_random_dates(input int count);
      for (int n = 0; n < count; n++) begin
         no_gaps = ($urandom_range(9, 0) == 0);
         send_date(random_date());
      end
      no_gaps = 1'b0;
   endtask

   // The sender goes quiet until the pipeline has emptied, then resumes.
   task automatic test_sender_pause();
      repeat (20) send_date(random_date());
      drain_results();
      repeat (20) send_date(random_date());
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   // Prints one line per mismatch, up to a cap, and counts all of them.
   task automatic report_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
         $display("MISMATCH at %0t: %s", $realtime, text);
      end
   endtask

   task automatic check_field(input string field, input logic [YEAR_W-1:0] got,
                              input logic [YEAR_W-1:0] want, input req_type date);
      if (got !== want) begin
         report_mismatch($sformatf("%s for %0d/%0d/%0d (d/m/y): got %0d, expected %0d",
                                   field, date.day_in, date.month_in, date.year_in,
                                   got, want));
      end
   endtask

   // Every strobed result is matched against the oldest outstanding
   // transaction. A strobe with nothing outstanding is a failure on its own.
   always @(posedge clock) begin
      if (!reset && $isunknown(rsp_strobe)) begin
         report_mismatch("result strobe is unknown");
      end else if (!reset && rsp_strobe) begin
         if (pending_steps.size() == 0) begin
            report_mismatch("result strobe with no transaction outstanding");
         end else begin
            oldest_step = pending_steps.pop_front();
            check_field("date_valid", YEAR_W'(rsp_data.date_valid),
                        YEAR_W'(oldest_step.answer.date_valid), oldest_step.date);
            check_field("succ_day", YEAR_W'(rsp_data.succ_day),
                        YEAR_W'(oldest_step.answer.succ_day), oldest_step.date);
            check_field("succ_month", YEAR_W'(rsp_data.succ_month),
                        YEAR_W'(oldest_step.answer.succ_month), oldest_step.date);
            check_field("succ_year", rsp_data.succ_year, oldest_step.answer.succ_year,
                        oldest_step.date);
            check_field("pred_day", YEAR_W'(rsp_data.pred_day),
                        YEAR_W'(oldest_step.answer.pred_day), oldest_step.date);
            check_field("pred_month", YEAR_W'(rsp_data.pred_month),
                        YEAR_W'(oldest_step.answer.pred_month), oldest_step.date);
            check_field("pred_year", rsp_data.pred_year, oldest_step.answer.pred_year,
                        oldest_step.date);
            check_field("ordinal_day", YEAR_W'(rsp_data.ordinal_day),
                        YEAR_W'(oldest_step.answer.ordinal_day), oldest_step.date);
         end
      end
   end

   // The watchdog counts cycles in which no transaction is accepted and no
   // result is strobed, and stops the run when the count hits the limit.
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d transactions outstanding",
                  pending_steps.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_calendar_corners();
      test_back_to_back(100);
      test_random_dates(1200);
      test_sender_pause();
      test_back_to_back(40);

      // Let the last transactions come out, then keep clocking so that any
      // stray strobe past the pipeline depth is still caught.
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_steps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
